// ===== sv/brl_pkg.sv =====
package brl_pkg;

  localparam int COORD_W       = 6;
  localparam int COLOR_W       = 24;
  localparam int DEC_W         = 10;
  localparam int INC_W         = 9;
  localparam int TILE_SIZE_DEF = 64;
  localparam int MAX_PIXELS    = 64;
  localparam int CNT_W         = $clog2(MAX_PIXELS);
  localparam int QUEUE_DEPTH   = 2;

  typedef logic [COORD_W-1:0]      coord_t;
  typedef logic [COLOR_W-1:0]      color_t;
  typedef logic signed [DEC_W-1:0] dec_t;
  typedef logic signed [INC_W-1:0] inc_t;

  localparam coord_t COORD_MAX = '1;

  // slope class of a line, after the endpoints are ordered left to right
  typedef enum logic [1:0] {
    SLOPE_SHALLOW_UP,
    SLOPE_STEEP_UP,
    SLOPE_SHALLOW_DOWN,
    SLOPE_STEEP_DOWN
  } slope_t;

  // one classified line, handed from the front end to the walker
  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t tx;
    coord_t ty;
    dec_t   dec;
    inc_t   inc_neg;
    inc_t   inc_pos;
    slope_t slope;
    color_t color;
  } line_desc_t;

endpackage

// ===== sv/brl_cmd_if.sv =====
interface brl_cmd_if import brl_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t start_x;
  coord_t start_y;
  coord_t end_x;
  coord_t end_y;
  color_t line_color;

  modport source (output valid, output start_x, output start_y, output end_x,
                  output end_y, output line_color, input ready);
  modport sink   (input valid, input start_x, input start_y, input end_x,
                  input end_y, input line_color, output ready);
endinterface

// ===== sv/brl_pix_if.sv =====
interface brl_pix_if import brl_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t pixel_x;
  coord_t pixel_y;
  color_t pixel_color;
  logic   last_pixel;

  modport source (output valid, output pixel_x, output pixel_y, output pixel_color,
                  output last_pixel, input ready);
  modport sink   (input valid, input pixel_x, input pixel_y, input pixel_color,
                  input last_pixel, output ready);
endinterface

// ===== sv/brl_front.sv =====
module brl_front import brl_pkg::*; #(
  parameter int TILE_SIZE = TILE_SIZE_DEF
) (
  brl_cmd_if.sink    cmd,
  input  logic       full,
  output logic       push,
  output line_desc_t desc
);

  localparam coord_t EDGE = coord_t'(TILE_SIZE - 1);

  function automatic coord_t clamp(input coord_t c);
    return (c > EDGE) ? EDGE : c;
  endfunction

  coord_t sx, sy, ex, ey;
  dec_t   dx, dy;

  always_comb begin
    sx = clamp(cmd.start_x);
    sy = clamp(cmd.start_y);
    ex = clamp(cmd.end_x);
    ey = clamp(cmd.end_y);
    if (sx > ex) begin
      sx = clamp(cmd.end_x);
      sy = clamp(cmd.end_y);
      ex = clamp(cmd.start_x);
      ey = clamp(cmd.start_y);
    end
    dx = dec_t'(ex) - dec_t'(sx);
    dy = dec_t'(ey) - dec_t'(sy);

    desc.x     = sx;
    desc.y     = sy;
    desc.tx    = ex;
    desc.ty    = ey;
    desc.color = cmd.line_color;

    if (dy >= 0 && dy <= dx) begin
      desc.slope   = SLOPE_SHALLOW_UP;
      desc.dec     = (dy <<< 1) - dx;
      desc.inc_neg = inc_t'(dy <<< 1);
      desc.inc_pos = inc_t'((dy - dx) <<< 1);
    end else if (dx < dy) begin
      desc.slope   = SLOPE_STEEP_UP;
      desc.dec     = (dx <<< 1) - dy;
      desc.inc_neg = inc_t'(dx <<< 1);
      desc.inc_pos = inc_t'((dx - dy) <<< 1);
    end else if (-dx <= dy) begin
      desc.slope   = SLOPE_SHALLOW_DOWN;
      desc.dec     = -(dy <<< 1) - dx;
      desc.inc_neg = inc_t'(-(dy <<< 1));
      desc.inc_pos = inc_t'(-((dy + dx) <<< 1));
    end else begin
      desc.slope   = SLOPE_STEEP_DOWN;
      desc.dec     = (dx <<< 1) + dy;
      desc.inc_neg = inc_t'(dx <<< 1);
      desc.inc_pos = inc_t'((dx + dy) <<< 1);
    end
  end

  assign cmd.ready = !full;
  assign push      = cmd.valid && !full;

endmodule

// ===== sv/brl_queue.sv =====
module brl_queue import brl_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  line_desc_t wdata,
  output logic       full,
  input  logic       pop,
  output line_desc_t rdata,
  output logic       nonempty
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);

  line_desc_t        mem [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wp, rp;
  logic [CNT_QW-1:0] cnt;

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full     = (cnt == CNT_QW'(QUEUE_DEPTH));
  assign nonempty = (cnt != '0);
  assign rdata    = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (push) begin
        mem[wp] <= wdata;
        wp      <= bump(wp);
      end
      if (pop) begin
        rp <= bump(rp);
      end
      if (push && !pop) begin
        cnt <= cnt + 1'b1;
      end else if (pop && !push) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

endmodule

// ===== sv/brl_walk.sv =====
module brl_walk import brl_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       q_valid,
  input  line_desc_t q_desc,
  output logic       pop,
  brl_pix_if.source  pix
);

  // walker state
  logic             busy;
  coord_t           x, y, tx, ty;
  dec_t             dec;
  inc_t             inc_neg, inc_pos;
  slope_t           slope;
  color_t           color;
  logic [CNT_W-1:0] n;

  // output register
  logic   ov;
  coord_t ox, oy;
  color_t ocol;
  logic   olast;

  logic   emit, last, load, neg;
  logic   step_x, step_up, step_dn;
  coord_t x_next, y_next;
  dec_t   dec_next;

  always_comb begin
    emit = busy && (!ov || pix.ready);
    last = ((x == tx) && (y == ty)) || (n == CNT_W'(MAX_PIXELS - 1));
    load = q_valid && (!busy || (emit && last));
    neg  = dec[DEC_W-1];

    step_x  = 1'b0;
    step_up = 1'b0;
    step_dn = 1'b0;
    case (slope)
      SLOPE_SHALLOW_UP: begin
        step_x  = 1'b1;
        step_up = !neg;
      end
      SLOPE_STEEP_UP: begin
        step_x  = !neg;
        step_up = 1'b1;
      end
      SLOPE_SHALLOW_DOWN: begin
        step_x  = 1'b1;
        step_dn = !neg;
      end
      SLOPE_STEEP_DOWN: begin
        step_x  = !neg;
        step_dn = 1'b1;
      end
      default: begin
        step_x = 1'b0;
      end
    endcase

    // saturate at the edges of the coordinate range
    x_next = (step_x && x != COORD_MAX) ? x + 1'b1 : x;
    if (step_up && y != COORD_MAX) begin
      y_next = y + 1'b1;
    end else if (step_dn && y != '0) begin
      y_next = y - 1'b1;
    end else begin
      y_next = y;
    end
    dec_next = dec + dec_t'(neg ? inc_neg : inc_pos);
  end

  assign pop = load;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      ov   <= 1'b0;
      n    <= '0;
    end else begin
      if (emit) begin
        ov    <= 1'b1;
        ox    <= x;
        oy    <= y;
        ocol  <= color;
        olast <= last;
        if (!last) begin
          x   <= x_next;
          y   <= y_next;
          dec <= dec_next;
          n   <= n + 1'b1;
        end
      end else if (pix.ready) begin
        ov <= 1'b0;
      end
      if (load) begin
        busy    <= 1'b1;
        x       <= q_desc.x;
        y       <= q_desc.y;
        tx      <= q_desc.tx;
        ty      <= q_desc.ty;
        dec     <= q_desc.dec;
        inc_neg <= q_desc.inc_neg;
        inc_pos <= q_desc.inc_pos;
        slope   <= q_desc.slope;
        color   <= q_desc.color;
        n       <= '0;
      end else if (emit && last) begin
        busy <= 1'b0;
      end
    end
  end

  assign pix.valid       = ov;
  assign pix.pixel_x     = ox;
  assign pix.pixel_y     = oy;
  assign pix.pixel_color = ocol;
  assign pix.last_pixel  = olast;

endmodule

// ===== sv/bresenham_line_raster.sv =====
// Line rasterizer for one square tile. Each request on cmd carries a start
// point, an end point and a 24-bit color; the block answers with the pixels
// of the integer Bresenham line on pix, ordered from the left endpoint (the
// endpoints are swapped when start_x > end_x; equal columns keep the given
// order). Every pixel carries the color, and the end point comes last with
// last_pixel set, so a zero-length line is a single pixel. Coordinates at
// or beyond TILE_SIZE are clamped to TILE_SIZE-1 on entry. A line has
// max(|dx|,|dy|)+1 pixels, up to 64, sent at one pixel per cycle while
// pix is not stalled; the walker's decision update sets this rate, and
// consecutive lines follow back to back. The first pixel of a request
// passes through the queue, the walker registers and the output register
// before it shows on pix. A two-entry queue holds classified requests, so
// cmd keeps accepting while the queue has a free entry, also while a line
// is walked and while a pixel waits in the output register.
module bresenham_line_raster import brl_pkg::*; #(
  parameter int TILE_SIZE = TILE_SIZE_DEF
) (
  input  logic      clk,
  input  logic      rst,
  brl_cmd_if.sink   cmd,
  brl_pix_if.source pix
);

  // front end -> queue
  logic       push;
  logic       full;
  line_desc_t wdesc;

  // queue -> walker
  logic       pop;
  logic       q_valid;
  line_desc_t q_desc;

  // ordering, clamping and slope classification of each request
  brl_front #(
    .TILE_SIZE (TILE_SIZE)
  ) u_front (
    .cmd  (cmd),
    .full (full),
    .push (push),
    .desc (wdesc)
  );

  // decouples request intake from the pixel walk
  brl_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wdata    (wdesc),
    .full     (full),
    .pop      (pop),
    .rdata    (q_desc),
    .nonempty (q_valid)
  );

  // steps the decision value and emits one pixel per cycle while pix is not stalled
  brl_walk u_walk (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_desc  (q_desc),
    .pop     (pop),
    .pix     (pix)
  );

endmodule

// ===== sv/brl_check.sv =====
module brl_check import brl_pkg::*; (
  input logic   clk,
  input logic   rst,
  input logic   cmd_valid,
  input logic   cmd_ready,
  input logic   pix_valid,
  input logic   pix_ready,
  input coord_t pix_x,
  input coord_t pix_y,
  input color_t pix_color,
  input logic   pix_last
);

  logic       cmd_take, pix_take;
  logic       mid;
  coord_t     px, py;
  color_t     pc;
  logic [2:0] lines;

  assign cmd_take = cmd_valid && cmd_ready;
  assign pix_take = pix_valid && pix_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      mid   <= 1'b0;
      lines <= '0;
    end else begin
      if (pix_take) begin
        mid <= !pix_last;
        px  <= pix_x;
        py  <= pix_y;
        pc  <= pix_color;
      end
      if (cmd_take && !(pix_take && pix_last)) begin
        lines <= lines + 1'b1;
      end else if (!cmd_take && pix_take && pix_last) begin
        lines <= lines - 1'b1;
      end
    end
  end

  a_pix_hold: assert property (@(posedge clk) disable iff (rst)
    pix_valid && !pix_ready |=> pix_valid && $stable({pix_x, pix_y, pix_color, pix_last}))
    else $error("pixel changed while stalled");

  a_adjacent: assert property (@(posedge clk) disable iff (rst)
    pix_take && mid |-> (pix_x == px || pix_x == coord_t'(px + 1'b1)) &&
      (pix_y == py || pix_y == coord_t'(py + 1'b1) || pix_y == coord_t'(py - 1'b1)))
    else $error("pixel not adjacent to previous one");

  a_color: assert property (@(posedge clk) disable iff (rst)
    pix_take && mid |-> pix_color == pc)
    else $error("color changed within a line");

  a_owned: assert property (@(posedge clk) disable iff (rst)
    pix_valid |-> lines != '0)
    else $error("pixel without an open line request");

endmodule

bind bresenham_line_raster brl_check u_brl_check (
  .clk       (clk),
  .rst       (rst),
  .cmd_valid (cmd.valid),
  .cmd_ready (cmd.ready),
  .pix_valid (pix.valid),
  .pix_ready (pix.ready),
  .pix_x     (pix.pixel_x),
  .pix_y     (pix.pixel_y),
  .pix_color (pix.pixel_color),
  .pix_last  (pix.last_pixel)
);
